>>> rtl/core/hbs_pkg.sv
// Shared types and constants of the height-map brush and bilinear sampler.
// No dependencies; every other file of the block except hbs_ram uses this package.
package hbs_pkg;

    localparam int ACT_W   = 2;
    localparam int POS_W   = 17;
    localparam int HGT_W   = 24;
    localparam int RAT_W   = 16;
    localparam int CFG_W   = 8;
    localparam int FRAC_W  = 16;
    localparam int QUOT_W  = 24;
    localparam int WGT_W   = 17;

    typedef logic [ACT_W-1:0]        act_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic signed [HGT_W-1:0] hgt_t;
    typedef logic [RAT_W-1:0]        ratio_t;

    // action codes
    localparam act_t ACT_SAMPLE   = 2'd0;
    localparam act_t ACT_RAISE    = 2'd1;
    localparam act_t ACT_EXCAVATE = 2'd2;

    // register index of grid_resolution
    localparam logic REG_GRID_RES = 1'b0;

    localparam pos_t           POS_ONE      = 17'd65536;
    localparam hgt_t           HEIGHT_RESET = 24'sd17920;
    localparam hgt_t           HEIGHT_MAX   = 24'sd8388607;
    localparam logic [CFG_W-1:0] RES_RESET  = 8'd200;
    localparam logic [63:0]    EXP_M1_Q32   = 64'd1580030169;

endpackage

>>> rtl/core/hbs_if.sv
// Stream channels of the brush and sampler: input items and result items.
// Depends on hbs_pkg for the payload types.
interface hbs_in_if;
    logic            valid;
    logic            ready;
    hbs_pkg::act_t   action;
    hbs_pkg::pos_t   pos_u;
    hbs_pkg::pos_t   pos_v;
    hbs_pkg::hgt_t   brush_height;
    hbs_pkg::ratio_t radius_ratio;

    modport source (output valid, action, pos_u, pos_v, brush_height, radius_ratio,
                    input ready);
    modport sink (input valid, action, pos_u, pos_v, brush_height, radius_ratio,
                  output ready);
endinterface

interface hbs_out_if;
    logic          valid;
    logic          ready;
    hbs_pkg::hgt_t height_out;
    hbs_pkg::act_t action_done;

    modport source (output valid, height_out, action_done, input ready);
    modport sink (input valid, height_out, action_done, output ready);
endinterface

>>> rtl/core/hbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/hbs_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, fraction rem/den.
// Depends on hbs_pkg for the quotient width.
module hbs_div_pipe #(
    parameter int DEN_W = 53,
    parameter int TAG_W = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [DEN_W-1:0]          in_rem,
    input  logic [DEN_W-1:0]          den,
    input  logic [TAG_W-1:0]          in_tag,
    output logic                      out_valid,
    output logic [hbs_pkg::QUOT_W-1:0] out_q,
    output logic [TAG_W-1:0]          out_tag
);
    import hbs_pkg::*;

    logic [QUOT_W-1:0] vld_reg;
    logic [DEN_W-1:0]  rem_reg [QUOT_W];
    logic [QUOT_W-1:0] q_reg   [QUOT_W];
    logic [TAG_W-1:0]  tag_reg [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_stage
        logic              src_vld;
        logic [DEN_W-1:0]  src_rem;
        logic [QUOT_W-1:0] src_q;
        logic [TAG_W-1:0]  src_tag;
        logic [DEN_W:0]    shifted;
        logic              ge;
        logic [DEN_W:0]    diff;
        logic [DEN_W-1:0]  rem_next;
        logic [QUOT_W-1:0] q_next;

        if (k == 0)
        begin : g_first
            assign src_vld = in_valid;
            assign src_rem = in_rem;
            assign src_q   = '0;
            assign src_tag = in_tag;
        end
        else
        begin : g_rest
            assign src_vld = vld_reg[k-1];
            assign src_rem = rem_reg[k-1];
            assign src_q   = q_reg[k-1];
            assign src_tag = tag_reg[k-1];
        end

        // one restoring step: double, compare, subtract
        assign shifted  = {src_rem, 1'b0};
        assign ge       = shifted >= {1'b0, den};
        assign diff     = shifted - {1'b0, den};
        assign rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        assign q_next   = {src_q[QUOT_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            q_reg[k]   <= q_next;
            tag_reg[k] <= src_tag;
        end
    end

    assign out_valid = vld_reg[QUOT_W-1];
    assign out_q     = q_reg[QUOT_W-1];
    assign out_tag   = tag_reg[QUOT_W-1];
endmodule

>>> rtl/core/heightmap_brush_and_bilinear_sample.sv
// Top level of the height-map brush and bilinear sampler.
// Depends on hbs_pkg, hbs_if, hbs_ram and hbs_div_pipe.
//
// Usage:
//   item_in carries one action per beat (sample, gaussian raise, excavate);
//   result_out returns one beat per item: the sampled height for a sample,
//   zero for edits, and the action code echoed. grid_resolution is written
//   over the APB port at byte address 0, by the user only while the block is
//   idle; the block itself does not enforce this. A sample runs the setup
//   multiplies, four grid reads on the single RAM read port and three lerps
//   on one multiplier, in that order. A raise or excavate scans the grid
//   one cell per cycle, and a raise runs each cell through a 24-stage
//   divider and a read-modify-write pipeline before the drain completes.
//   Unused action code 3 goes straight to its result beat.
//   One item is worked on at a time; item_in.ready is high only when idle.
//   Reset and every resolution write start a clearing pass over all
//   (MAX_RES+1)^2 cells (65536 by default) that writes 70.0 into every
//   cell; no item is accepted during it, register writes still are.
//   A result waits in an output register while the receiver stalls; the
//   next item is accepted meanwhile and finishes only once that beat leaves.
module heightmap_brush_and_bilinear_sample #(
    parameter int MAX_RES         = 255,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    hbs_in_if.sink       item_in,
    hbs_out_if.source    result_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import hbs_pkg::*;

    localparam int SIDE    = MAX_RES + 1;
    localparam int DEPTH_G = SIDE * SIDE;
    localparam int RW      = $clog2(MAX_RES + 1);
    localparam int AW      = $clog2(DEPTH_G);
    localparam int XW      = FRAC_W + RW;
    localparam int SQW     = 2 * XW;
    localparam int D2W     = SQW + 1;
    localparam int DENW    = SQW + 5;
    localparam int IW      = $clog2(EXP_TABLE_DEPTH);
    localparam int CW      = (RW > CFG_W) ? RW : CFG_W;
    localparam int DRAIN   = QUOT_W + 4;
    localparam int DRW     = $clog2(DRAIN + 1);
    localparam int PW      = HGT_W + WGT_W + 1;
    localparam logic [RW-1:0]  RES_INIT = (MAX_RES < 200) ? RW'(MAX_RES) : RW'(RES_RESET);
    localparam logic [SQW+1:0] SQ_STEP  = (SQW + 2)'(1) << (2 * FRAC_W);

    typedef enum logic [3:0] {
        ST_FILL, ST_IDLE, ST_MX, ST_MY, ST_MS, ST_SQX, ST_SQY, ST_SQS,
        ST_SCAN, ST_DRAIN, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_LERP, ST_DONE
    } state_t;

    // exp(-x) weight, Q16, evaluated at elaboration for each table entry
    function automatic logic [WGT_W-1:0] exp_neg_q16(input int idx);
        logic [63:0]        xq;
        logic [63:0]        n;
        logic [63:0]        f;
        logic [63:0]        term;
        logic [63:0]        res;
        logic [63:0]        w;
        logic signed [63:0] sum;
        xq   = (64'(idx) << 36) / 64'(EXP_TABLE_DEPTH);
        n    = xq >> 32;
        f    = xq & 64'hFFFF_FFFF;
        term = 64'h1_0000_0000;
        sum  = $signed(term);
        for (int k = 1; k <= 13; k++)
        begin
            term = ((term * f) >> 32) / 64'(k);
            if ((k % 2) == 1)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        res = (sum > 0) ? $unsigned(sum) : 64'd0;
        for (int k = 0; k < 16; k++)
        begin
            if (64'(k) < n)
            begin
                res = (res * EXP_M1_Q32) >> 32;
            end
        end
        w = (res + 64'd32768) >> 16;
        return (w > 64'd65536) ? WGT_W'(65536) : w[WGT_W-1:0];
    endfunction

    logic [WGT_W-1:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_exp
        assign exp_rom[g] = exp_neg_q16(g);
    end

    // control registers
    state_t           state_reg, state_next;
    logic [RW-1:0]    res_reg, res_next;
    logic [AW-1:0]    fill_cnt_reg, fill_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [DRW-1:0]   drain_reg, drain_next;
    logic [RW-1:0]    r_reg, r_next;
    logic [RW-1:0]    c_reg, c_next;

    // item and datapath registers
    act_t             act_reg, act_next;
    pos_t             u_reg, u_next;
    pos_t             v_reg, v_next;
    hgt_t             h_reg, h_next;
    ratio_t           ratio_reg, ratio_next;
    logic [XW-1:0]    x0_reg, x0_next;
    logic [XW-1:0]    y0_reg, y0_next;
    logic [XW-1:0]    sig_reg, sig_next;
    logic [SQW-1:0]   x0sq_reg, x0sq_next;
    logic [SQW-1:0]   y0sq_reg, y0sq_next;
    logic [SQW-1:0]   sigsq_reg, sigsq_next;
    logic [XW+1:0]    dx_reg, dx_next;
    logic [XW+1:0]    dy_reg, dy_next;
    logic [SQW+1:0]   dx2_reg, dx2_next;
    logic [SQW+1:0]   dy2_reg, dy2_next;
    logic [AW-1:0]    row_base_reg, row_base_next;
    logic [AW-1:0]    addr_reg, addr_next;
    hgt_t             cell_a_reg, cell_a_next;
    hgt_t             cell_b_reg, cell_b_next;
    hgt_t             cell_c_reg, cell_c_next;
    hgt_t             v12_reg, v12_next;
    hgt_t             v34_reg, v34_next;
    logic [1:0]       lerp_cnt_reg, lerp_cnt_next;
    hgt_t             out_height_reg, out_height_next;
    act_t             out_action_reg, out_action_next;

    // raise pipeline after the divider
    logic             g1_valid_reg;
    logic [AW-1:0]    g1_addr_reg;
    logic [WGT_W-1:0] g1_w_reg;
    logic             g2_valid_reg;
    logic [AW-1:0]    g2_addr_reg;
    logic signed [PW-1:0] g2_prod_reg;
    hgt_t             g2_cell_reg;

    // RAM and divider wiring
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    hgt_t             ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [HGT_W-1:0] ram_rdata;
    hgt_t             cell_rd;
    logic             div_in_valid;
    logic             div_out_valid;
    logic [QUOT_W-1:0] div_q;
    logic [AW-1:0]    div_tag;

    // APB decode
    logic             cfg_wr;
    logic [CW-1:0]    cfg_val;
    logic [RW-1:0]    cfg_res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_GRID_RES);
    assign cfg_val = CW'(pwdata[CFG_W-1:0]);
    assign cfg_res = (cfg_val == '0) ? RW'(1) :
                     (cfg_val > CW'(MAX_RES)) ? RW'(MAX_RES) : RW'(cfg_val);
    assign prdata  = (paddr[2] == REG_GRID_RES) ? 32'(res_reg) : 32'd0;

    // shared setup multiplier
    logic [XW-1:0]  mul_a, mul_b;
    logic [SQW-1:0] mul_p;

    always_comb
    begin
        mul_a = x0_reg;
        mul_b = x0_reg;
        case (state_reg)
            ST_MX:   begin mul_a = XW'(u_reg);     mul_b = XW'(res_reg); end
            ST_MY:   begin mul_a = XW'(v_reg);     mul_b = XW'(res_reg); end
            ST_MS:   begin mul_a = XW'(ratio_reg); mul_b = XW'(res_reg); end
            ST_SQY:  begin mul_a = y0_reg;         mul_b = y0_reg;       end
            ST_SQS:  begin mul_a = sig_reg;        mul_b = sig_reg;      end
            default: begin mul_a = x0_reg;         mul_b = x0_reg;       end
        endcase
    end
    assign mul_p = SQW'(mul_a) * SQW'(mul_b);

    // shared lerp: a + (b - a) * f, rounded to nearest with floor
    hgt_t                lerp_a, lerp_b;
    logic [FRAC_W-1:0]   lerp_f;
    logic signed [HGT_W:0]   lerp_diff;
    logic signed [41:0]  lerp_prod;
    logic signed [41:0]  lerp_sum;
    hgt_t                lerp_y;

    always_comb
    begin
        case (lerp_cnt_reg)
            2'd0:    begin lerp_a = cell_c_reg; lerp_b = cell_rd;    lerp_f = y0_reg[FRAC_W-1:0]; end
            2'd1:    begin lerp_a = cell_a_reg; lerp_b = cell_b_reg; lerp_f = y0_reg[FRAC_W-1:0]; end
            default: begin lerp_a = v12_reg;    lerp_b = v34_reg;    lerp_f = x0_reg[FRAC_W-1:0]; end
        endcase
    end
    assign lerp_diff = (HGT_W + 1)'(lerp_b) - (HGT_W + 1)'(lerp_a);
    assign lerp_prod = 42'(lerp_diff) * 42'($signed({1'b0, lerp_f}));
    assign lerp_sum  = (42'(lerp_a) <<< FRAC_W) + lerp_prod + 42'sd32768;
    assign lerp_y    = lerp_sum[HGT_W+FRAC_W-1:FRAC_W];

    // sample cell addresses with the second index clamped at the edge
    logic [RW-1:0] r1, r2, c1, c2;
    logic [AW-1:0] samp_addr;

    assign r1 = y0_reg[XW-1:FRAC_W];
    assign c1 = x0_reg[XW-1:FRAC_W];
    assign r2 = (r1 == res_reg) ? r1 : r1 + RW'(1);
    assign c2 = (c1 == res_reg) ? c1 : c1 + RW'(1);

    always_comb
    begin
        case (state_reg)
            ST_RD0:  samp_addr = AW'(AW'(r1) * AW'(SIDE)) + AW'(c1);
            ST_RD1:  samp_addr = AW'(AW'(r2) * AW'(SIDE)) + AW'(c1);
            ST_RD2:  samp_addr = AW'(AW'(r1) * AW'(SIDE)) + AW'(c2);
            default: samp_addr = AW'(AW'(r2) * AW'(SIDE)) + AW'(c2);
        endcase
    end

    // scan distance and brush hits
    logic [D2W-1:0]  d2;
    logic [DENW-1:0] den;
    logic            exc_hit;

    assign d2           = D2W'(dx2_reg[SQW-1:0]) + D2W'(dy2_reg[SQW-1:0]);
    assign den          = {sigsq_reg, 5'b0};
    assign div_in_valid = (state_reg == ST_SCAN) && (act_reg == ACT_RAISE)
                          && (DENW'(d2) < den);
    assign exc_hit      = (state_reg == ST_SCAN) && (act_reg == ACT_EXCAVATE)
                          && (d2 <= D2W'(sigsq_reg));

    assign item_in.ready          = (state_reg == ST_IDLE);
    assign result_out.valid       = out_valid_reg;
    assign result_out.height_out  = out_height_reg;
    assign result_out.action_done = out_action_reg;

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        res_next        = res_reg;
        fill_cnt_next   = fill_cnt_reg;
        out_valid_next  = out_valid_reg;
        drain_next      = drain_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        act_next        = act_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        h_next          = h_reg;
        ratio_next      = ratio_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        sig_next        = sig_reg;
        x0sq_next       = x0sq_reg;
        y0sq_next       = y0sq_reg;
        sigsq_next      = sigsq_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        dx2_next        = dx2_reg;
        dy2_next        = dy2_reg;
        row_base_next   = row_base_reg;
        addr_next       = addr_reg;
        cell_a_next     = cell_a_reg;
        cell_b_next     = cell_b_reg;
        cell_c_next     = cell_c_reg;
        v12_next        = v12_reg;
        v34_next        = v34_reg;
        lerp_cnt_next   = lerp_cnt_reg;
        out_height_next = out_height_reg;
        out_action_next = out_action_reg;

        // drop a delivered beat
        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_FILL:
            begin
                fill_cnt_next = fill_cnt_reg + AW'(1);
                if (fill_cnt_reg == AW'(DEPTH_G - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_in.valid)
                begin
                    act_next   = item_in.action;
                    u_next     = (item_in.pos_u > POS_ONE) ? POS_ONE : item_in.pos_u;
                    v_next     = (item_in.pos_v > POS_ONE) ? POS_ONE : item_in.pos_v;
                    h_next     = item_in.brush_height;
                    ratio_next = item_in.radius_ratio;
                    if (item_in.action == ACT_SAMPLE || item_in.action == ACT_RAISE
                        || item_in.action == ACT_EXCAVATE)
                    begin
                        state_next = ST_MX;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MX:
            begin
                x0_next    = mul_p[XW-1:0];
                state_next = ST_MY;
            end
            ST_MY:
            begin
                y0_next    = mul_p[XW-1:0];
                state_next = (act_reg == ACT_SAMPLE) ? ST_RD0 : ST_MS;
            end
            ST_MS:
            begin
                sig_next   = mul_p[XW-1:0];
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                x0sq_next  = mul_p;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                y0sq_next  = mul_p;
                state_next = ST_SQS;
            end
            ST_SQS:
            begin
                // load the scan origin
                sigsq_next    = mul_p;
                r_next        = '0;
                c_next        = '0;
                dx_next       = (XW + 2)'(0) - (XW + 2)'(x0_reg);
                dy_next       = (XW + 2)'(0) - (XW + 2)'(y0_reg);
                dx2_next      = (SQW + 2)'(x0sq_reg);
                dy2_next      = (SQW + 2)'(y0sq_reg);
                row_base_next = '0;
                addr_next     = '0;
                if (act_reg == ACT_RAISE && mul_p == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // advance one cell; squares follow by adding 2*K*d + K^2
                if (c_reg == res_reg)
                begin
                    c_next        = '0;
                    r_next        = r_reg + RW'(1);
                    dx_next       = (XW + 2)'(0) - (XW + 2)'(x0_reg);
                    dx2_next      = (SQW + 2)'(x0sq_reg);
                    dy_next       = dy_reg + ((XW + 2)'(1) << FRAC_W);
                    dy2_next      = dy2_reg + ((SQW + 2)'($signed(dy_reg)) << (FRAC_W + 1))
                                    + SQ_STEP;
                    row_base_next = row_base_reg + AW'(SIDE);
                    addr_next     = row_base_reg + AW'(SIDE);
                    if (r_reg == res_reg)
                    begin
                        drain_next = DRW'(DRAIN);
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    c_next    = c_reg + RW'(1);
                    dx_next   = dx_reg + ((XW + 2)'(1) << FRAC_W);
                    dx2_next  = dx2_reg + ((SQW + 2)'($signed(dx_reg)) << (FRAC_W + 1))
                                + SQ_STEP;
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - DRW'(1);
                if (drain_reg == DRW'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cell_a_next = cell_rd;
                state_next  = ST_RD2;
            end
            ST_RD2:
            begin
                cell_b_next = cell_rd;
                state_next  = ST_RD3;
            end
            ST_RD3:
            begin
                cell_c_next   = cell_rd;
                lerp_cnt_next = 2'd0;
                state_next    = ST_LERP;
            end
            ST_LERP:
            begin
                // second column first (cell d arrives in the first lerp cycle),
                // then the first column, then across
                lerp_cnt_next = lerp_cnt_reg + 2'd1;
                case (lerp_cnt_reg)
                    2'd0:    v34_next = lerp_y;
                    2'd1:    v12_next = lerp_y;
                    default:
                    begin
                        v12_next   = lerp_y;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_height_next = (act_reg == ACT_SAMPLE) ? v12_reg : '0;
                    out_action_next = act_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a resolution write restarts the clearing pass
        if (cfg_wr)
        begin
            res_next      = cfg_res;
            fill_cnt_next = '0;
            state_next    = ST_FILL;
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            res_reg       <= RES_INIT;
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            drain_reg     <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            lerp_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            fill_cnt_reg  <= fill_cnt_next;
            out_valid_reg <= out_valid_next;
            drain_reg     <= drain_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            lerp_cnt_reg  <= lerp_cnt_next;
        end
    end

    // hold datapath values
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        h_reg          <= h_next;
        ratio_reg      <= ratio_next;
        x0_reg         <= x0_next;
        y0_reg         <= y0_next;
        sig_reg        <= sig_next;
        x0sq_reg       <= x0sq_next;
        y0sq_reg       <= y0sq_next;
        sigsq_reg      <= sigsq_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        dx2_reg        <= dx2_next;
        dy2_reg        <= dy2_next;
        row_base_reg   <= row_base_next;
        addr_reg       <= addr_next;
        cell_a_reg     <= cell_a_next;
        cell_b_reg     <= cell_b_next;
        cell_c_reg     <= cell_c_next;
        v12_reg        <= v12_next;
        v34_reg        <= v34_next;
        out_height_reg <= out_height_next;
        out_action_reg <= out_action_next;
    end

    // gaussian weight divider over the scanned cells
    hbs_div_pipe #(
        .DEN_W (DENW),
        .TAG_W (AW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_in_valid),
        .in_rem    (DENW'(d2)),
        .den       (den),
        .in_tag    (addr_reg),
        .out_valid (div_out_valid),
        .out_q     (div_q),
        .out_tag   (div_tag)
    );

    // table index from the quotient
    logic [QUOT_W+IW:0] idx_full;
    logic [IW-1:0]      exp_idx;

    assign idx_full = (QUOT_W + IW + 1)'(div_q) * (QUOT_W + IW + 1)'(EXP_TABLE_DEPTH);
    assign exp_idx  = idx_full[QUOT_W+IW-1:QUOT_W];

    // raise read-modify-write: read and weight, then scale, then add and clamp
    logic signed [PW-1:0]       g1_prod;
    logic signed [PW-1:0]       g2_round;
    logic signed [HGT_W+2:0]    g2_sum;
    hgt_t                       g2_z;

    assign g1_prod  = PW'(h_reg) * PW'($signed({1'b0, g1_w_reg}));
    assign g2_round = g2_prod_reg + PW'(32768);
    assign g2_sum   = (HGT_W + 3)'(g2_cell_reg)
                      + (HGT_W + 3)'($signed(g2_round[PW-1:FRAC_W]));
    assign g2_z     = (g2_sum < 0) ? '0 :
                      (g2_sum > (HGT_W + 3)'(HEIGHT_MAX)) ? HEIGHT_MAX : g2_sum[HGT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
        end
        else
        begin
            g1_valid_reg <= div_out_valid;
            g2_valid_reg <= g1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g1_addr_reg <= div_tag;
        g1_w_reg    <= exp_rom[exp_idx];
        g2_addr_reg <= g1_addr_reg;
        g2_prod_reg <= g1_prod;
        g2_cell_reg <= cell_rd;
    end

    // grid memory port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = g2_addr_reg;
        ram_wdata = g2_z;
        if (state_reg == ST_FILL)
        begin
            ram_we    = 1'b1;
            ram_waddr = fill_cnt_reg;
            ram_wdata = HEIGHT_RESET;
        end
        else if (exc_hit)
        begin
            ram_we    = 1'b1;
            ram_waddr = addr_reg;
            ram_wdata = h_reg;
        end
        else if (g2_valid_reg)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = (state_reg == ST_RD0 || state_reg == ST_RD1 || state_reg == ST_RD2
                        || state_reg == ST_RD3) ? samp_addr : div_tag;
    assign cell_rd   = $signed(ram_rdata);

    hbs_ram #(
        .WIDTH (HGT_W),
        .DEPTH (DEPTH_G)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

>>> tb/heightmap_brush_and_bilinear_sample_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the height-map brush and bilinear sampler.
// Depends on hbs_pkg, hbs_if and the top level heightmap_brush_and_bilinear_sample.
module heightmap_brush_and_bilinear_sample_tb;
    import hbs_pkg::*;

    localparam int MAX_RES    = 255;
    localparam int EXP_DEPTH  = 256;
    localparam int SIDE       = MAX_RES + 1;
    localparam int N_DIRECTED = 13;

    typedef struct {
        act_t   action;
        pos_t   u;
        pos_t   v;
        hgt_t   h;
        ratio_t ratio;
        bit     typed;
        hgt_t   typed_h;
    } brush_cmd_t;

    typedef struct {
        hgt_t height;
        act_t action;
    } height_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    hbs_in_if  item_in ();
    hbs_out_if result_out ();

    heightmap_brush_and_bilinear_sample #(
        .MAX_RES(MAX_RES),
        .EXP_TABLE_DEPTH(EXP_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_in(item_in.sink),
        .result_out(result_out.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predictor state
    int          grid_q [SIDE*SIDE];
    int unsigned res_q;
    int unsigned exp_tab [EXP_DEPTH];

    height_beat_t expected_heights [$];
    bit           typed_flag_q [$];
    hgt_t         typed_height_q [$];
    int           fail_count = 0;
    bit           quiet = 1'b0;

    brush_cmd_t directed [N_DIRECTED];

    always #4 clk = ~clk;

    initial begin
        item_in.valid = 1'b0;
        item_in.action = '0;
        item_in.pos_u = '0;
        item_in.pos_v = '0;
        item_in.brush_height = '0;
        item_in.radius_ratio = '0;
        result_out.ready = 1'b0;
    end

    // Q16 value of exp(-16*i/depth): Taylor series on the fraction, exp(-1) per integer part
    function automatic int unsigned exp_weight(int unsigned i);
        longint unsigned xq, n, f, term, res, w;
        longint sum;
        xq = (longint'(i) << 36) / EXP_DEPTH;
        n = xq >> 32;
        f = xq & 64'hFFFF_FFFF;
        term = 64'd1 << 32;
        sum = longint'(term);
        for (int k = 1; k <= 13; k++) begin
            term = ((term * f) >> 32) / k;
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        res = (sum > 0) ? longint'(sum) : 0;
        for (longint unsigned k = 0; k < n; k++)
            res = (res * EXP_M1_Q32) >> 32;
        w = (res + 32768) >> 16;
        return (w > 65536) ? 65536 : int'(w);
    endfunction

    function automatic longint round16(longint n);
        return (n + 32768) >>> 16;
    endfunction

    function automatic longint lerp16(longint a, longint b, longint f);
        return round16(a * (65536 - f) + b * f);
    endfunction

    function automatic void refill_grid();
        foreach (grid_q[i]) grid_q[i] = HEIGHT_RESET;
    endfunction

    function automatic longint unsigned cell_dist2(int r, int c, longint x0, longint y0);
        longint dx, dy;
        dx = (longint'(c) << 16) - x0;
        dy = (longint'(r) << 16) - y0;
        return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    // apply one action to the grid copy and return its result height
    function automatic hgt_t apply_brush(act_t act, pos_t pu, pos_t pv, hgt_t ph, ratio_t pr);
        longint unsigned u, v, x, y, sig, den, rad2, d2, rem, q, idx;
        longint x0, y0, z, v12, v34, s, t;
        int c1, c2, r1, r2;
        int rr;
        u = (pu > POS_ONE) ? POS_ONE : pu;
        v = (pv > POS_ONE) ? POS_ONE : pv;
        rr = int'(res_q);
        x = u * res_q;
        y = v * res_q;
        x0 = longint'(x);
        y0 = longint'(y);
        case (act)
            ACT_SAMPLE: begin
                c1 = int'(x >> 16);
                r1 = int'(y >> 16);
                c2 = c1 + 1;
                r2 = r1 + 1;
                s = longint'(x & 16'hFFFF);
                t = longint'(y & 16'hFFFF);
                if (c1 > rr) c1 = rr;
                if (c2 > rr) c2 = rr;
                if (r1 > rr) r1 = rr;
                if (r2 > rr) r2 = rr;
                v12 = lerp16(grid_q[r1*SIDE+c1], grid_q[r2*SIDE+c1], t);
                v34 = lerp16(grid_q[r1*SIDE+c2], grid_q[r2*SIDE+c2], t);
                return hgt_t'(lerp16(v12, v34, s));
            end
            ACT_RAISE: begin
                sig = longint'(pr) * res_q;
                den = 32 * sig * sig;
                if (den == 0) return '0;
                for (int r = 0; r <= rr; r++) begin
                    for (int c = 0; c <= rr; c++) begin
                        d2 = cell_dist2(r, c, x0, y0);
                        if (d2 >= den) continue;
                        rem = d2;
                        q = 0;
                        for (int b = 0; b < QUOT_W; b++) begin
                            rem = rem << 1;
                            q = q << 1;
                            if (rem >= den) begin
                                rem -= den;
                                q |= 1;
                            end
                        end
                        idx = (q * EXP_DEPTH) >> 24;
                        if (idx >= EXP_DEPTH) continue;
                        z = grid_q[r*SIDE+c] + round16(longint'(ph) * exp_tab[idx]);
                        if (z < 0) z = 0;
                        if (z > HEIGHT_MAX) z = HEIGHT_MAX;
                        grid_q[r*SIDE+c] = int'(z);
                    end
                end
                return '0;
            end
            ACT_EXCAVATE: begin
                sig = longint'(pr) * res_q;
                rad2 = sig * sig;
                for (int r = 0; r <= rr; r++)
                    for (int c = 0; c <= rr; c++)
                        if (cell_dist2(r, c, x0, y0) <= rad2)
                            grid_q[r*SIDE+c] = int'(ph);
                return '0;
            end
            default: return '0;
        endcase
    endfunction

    // predict on each accepted item, check each accepted result
    always @(posedge clk) begin
        height_beat_t pred, got;
        bit typed;
        hgt_t typed_h;
        if (item_in.valid && item_in.ready) begin
            pred.action = item_in.action;
            pred.height = apply_brush(item_in.action, item_in.pos_u, item_in.pos_v,
                                      item_in.brush_height, item_in.radius_ratio);
            typed = typed_flag_q.pop_front();
            typed_h = typed_height_q.pop_front();
            if (typed) pred.height = typed_h;
            expected_heights.push_back(pred);
        end
        if (result_out.valid && result_out.ready) begin
            got.height = result_out.height_out;
            got.action = result_out.action_done;
            if (expected_heights.size() == 0) begin
                $error("result beat with no expectation: height_out %0d", got.height);
                fail_count++;
            end else begin
                pred = expected_heights.pop_front();
                if (got.height !== pred.height) begin
                    $error("height_out: expected %0d actual %0d", pred.height, got.height);
                    fail_count++;
                end
                if (got.action !== pred.action) begin
                    $error("action_done: expected %0d actual %0d", pred.action, got.action);
                    fail_count++;
                end
            end
        end
    end

    // stall the result side at random
    always @(negedge clk)
        result_out.ready <= quiet || ($urandom_range(99) >= 15);

    task automatic send_cmd(brush_cmd_t cmd);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 15) begin
            item_in.valid = 1'b0;
            @(negedge clk);
        end
        typed_flag_q.push_back(cmd.typed);
        typed_height_q.push_back(cmd.typed_h);
        item_in.valid = 1'b1;
        item_in.action = cmd.action;
        item_in.pos_u = cmd.u;
        item_in.pos_v = cmd.v;
        item_in.brush_height = cmd.h;
        item_in.radius_ratio = cmd.ratio;
        @(posedge clk);
        while (!item_in.ready) @(posedge clk);
    endtask

    // hold until every result is back, then write the resolution register
    task automatic write_resolution(logic [31:0] value);
        int unsigned r;
        @(negedge clk);
        item_in.valid = 1'b0;
        while (expected_heights.size() != 0) @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 3'(REG_GRID_RES) * 3'd4;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        r = value & 8'hFF;
        if (r == 0) r = 1;
        if (r > MAX_RES) r = MAX_RES;
        res_q = r;
        refill_grid();
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic brush_cmd_t random_cmd();
        brush_cmd_t cmd;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) cmd.action = ACT_SAMPLE;
        else if (pick < 65) cmd.action = ACT_RAISE;
        else if (pick < 90) cmd.action = ACT_EXCAVATE;
        else cmd.action = act_t'(2'd3);
        cmd.u = ($urandom_range(9) == 0) ? pos_t'($urandom) : pos_t'($urandom_range(65536));
        cmd.v = ($urandom_range(9) == 0) ? pos_t'($urandom) : pos_t'($urandom_range(65536));
        cmd.h = hgt_t'($urandom);
        cmd.ratio = ($urandom_range(1) == 0) ? ratio_t'($urandom_range(16384)) : ratio_t'($urandom);
        cmd.typed = 1'b0;
        cmd.typed_h = '0;
        return cmd;
    endfunction

    initial begin
        int unsigned res_plan [4] = '{0, 1, 7, 30};
        int wait_cycles;
        // edits and sample at the default resolution, then at the full size
        directed = '{
            '{ACT_SAMPLE,   17'd0,      17'd0,      24'sd0,        16'd0,     1'b1, HEIGHT_RESET},
            '{ACT_SAMPLE,   POS_ONE,    POS_ONE,    24'sd0,        16'd0,     1'b1, HEIGHT_RESET},
            '{ACT_SAMPLE,   17'h1FFFF,  17'h1FFFF,  24'sd0,        16'd0,     1'b1, HEIGHT_RESET},
            '{act_t'(2'd3), 17'h1FFFF,  17'h1FFFF,  -24'sd8388608, 16'hFFFF,  1'b1, 24'sd0},
            '{ACT_EXCAVATE, 17'd32768,  17'd32768,  -24'sd8388608, 16'd0,     1'b1, 24'sd0},
            '{ACT_SAMPLE,   17'd32768,  17'd32768,  24'sd0,        16'd0,     1'b0, 24'sd0},
            '{ACT_RAISE,    17'd32768,  17'd32768,  24'sd8388607,  16'd0,     1'b1, 24'sd0},
            '{ACT_RAISE,    17'd0,      17'd65536,  24'sd8388607,  16'hFFFF,  1'b1, 24'sd0},
            '{ACT_SAMPLE,   17'd12345,  17'd54321,  24'sd0,        16'd0,     1'b0, 24'sd0},
            '{ACT_RAISE,    17'd40000,  17'd20000,  -24'sd8388608, 16'd3000,  1'b1, 24'sd0},
            '{ACT_EXCAVATE, 17'd65536,  17'd0,      24'sd8388607,  16'd20000, 1'b1, 24'sd0},
            '{ACT_SAMPLE,   17'd40000,  17'd20000,  24'sd0,        16'd0,     1'b0, 24'sd0},
            '{ACT_SAMPLE,   17'd65535,  17'd1,      24'sd0,        16'd0,     1'b0, 24'sd0}
        };
        foreach (exp_tab[i]) exp_tab[i] = exp_weight(i);
        res_q = RES_RESET;
        refill_grid();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i]) send_cmd(directed[i]);

        // full-size grid: far-corner raise and edge samples
        write_resolution(32'd255);
        send_cmd('{ACT_RAISE, POS_ONE, POS_ONE, 24'sd100000, 16'd4000, 1'b1, 24'sd0});
        send_cmd('{ACT_SAMPLE, POS_ONE, POS_ONE, 24'sd0, 16'd0, 1'b0, 24'sd0});
        send_cmd('{ACT_SAMPLE, 17'd65000, 17'd65400, 24'sd0, 16'd0, 1'b0, 24'sd0});

        // random phases over small grids, one run without idling
        for (int p = 0; p < 4; p++) begin
            write_resolution(res_plan[p] | ($urandom & 32'hFFFF_FF00));
            for (int n = 0; n < 25; n++) begin
                quiet = (p == 2);
                send_cmd(random_cmd());
            end
            quiet = 1'b0;
        end

        // drain
        @(negedge clk);
        item_in.valid = 1'b0;
        wait_cycles = 0;
        while (expected_heights.size() != 0 && wait_cycles < 200000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        if (fail_count == 0 && expected_heights.size() == 0)
            $display("heightmap_brush_and_bilinear_sample regression: pass");
        else
            $display("heightmap_brush_and_bilinear_sample regression: fail");
        $finish;
    end

    // hard stop for a hung run
    initial begin
        #40_000_000;
        $display("heightmap_brush_and_bilinear_sample regression: fail");
        $finish;
    end

endmodule

>>> heightmap_brush_and_bilinear_sample.f
rtl/core/hbs_pkg.sv
rtl/core/hbs_if.sv
rtl/core/hbs_ram.sv
rtl/core/hbs_div_pipe.sv
rtl/core/heightmap_brush_and_bilinear_sample.sv
tb/heightmap_brush_and_bilinear_sample_tb.sv
